### design/bounded_deque_with_index_access_core_macros.svh
`ifndef BOUNDED_DEQUE_WITH_INDEX_ACCESS_CORE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_INDEX_ACCESS_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

   localparam int DATA_BITS      = 32;
   localparam int MODE_BITS      = 4;
   localparam int POS_BITS       = 4;
   localparam int STATUS_BITS    = 2;
   localparam int COUNT_BITS     = 5;
   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_VALUE_BITS = 32;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_APPEND     = 4'd0,
      MODE_PREPEND    = 4'd1,
      MODE_POP_FRONT  = 4'd2,
      MODE_POP_BACK   = 4'd3,
      MODE_PEEK_FRONT = 4'd4,
      MODE_PEEK_BACK  = 4'd5,
      MODE_READ       = 4'd6,
      MODE_WRITE      = 4'd7,
      MODE_SEARCH     = 4'd8
   } mode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic shift_left;
      logic shift_right;
   } cell_ctrl_type;

endpackage

### design/bounded_deque_with_index_access_core.sv
`timescale 1ns / 1ps
// front requests (prepend, pop/peek front), error results and unknown modes: the result is
//   registered in the done state, then moved to the output register once it is free
// back, indexed, append and search requests rotate the cell chain once in the scan state,
//   one step per cycle, and then pass their result on through the done state
// a finished result waits in the output register while the next request is taken
// synchronous reset empties the deque and clears the handshake; cell contents are not cleared

module bounded_deque_with_index_access_core import bdq_pkg::*; #(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [MODE_BITS-1:0]          req_mode,
   input  logic signed [DATA_BITS-1:0]   req_value,
   input  logic [POS_BITS-1:0]           req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [DATA_BITS-1:0]   rsp_data,
   output logic [STATUS_BITS-1:0]        rsp_status,
   output logic                          rsp_found,
   output logic [POS_BITS-1:0]           rsp_found_position,
   output logic [COUNT_BITS-1:0]         rsp_count
);

`include "bounded_deque_with_index_access_core_macros.svh"

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = CNT_W + POS_BITS;
   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      step_ff, step_in;
   mode_type              op_ff, op_in;
   logic [CNT_W-1:0]      tgt_ff, tgt_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DATA_BITS-1:0]  res_data_ff, res_data_in;
   status_type            res_status_ff, res_status_in;
   logic                  res_found_ff, res_found_in;
   logic [POS_BITS-1:0]   res_fpos_ff, res_fpos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [POS_BITS-1:0]   rsp_fpos_ff, rsp_fpos_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   cell_ctrl_type         cell_ctrl;
   logic [VALUE_BITS-1:0] head_in;
   logic [VALUE_BITS-1:0] tail_in;
   logic [VALUE_BITS-1:0] cell_q [CAPACITY];

   logic [VALUE_BITS-1:0] store_val;
   logic [DATA_BITS-1:0]  head_data;
   logic                  is_full;
   logic                  no_entries;
   logic                  pos_beyond;
   logic                  step_last;
   logic                  step_hit;
   logic [CNT_W-1:0]      step_cnt;

   // cell chain: position 0 at the front
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_BITS-1:0] prev_d;
      logic [VALUE_BITS-1:0] next_d;
      if (i == 0) begin : g_first
         assign prev_d = head_in;
      end else begin : g_inner_prev
         assign prev_d = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_d = tail_in;
      end else begin : g_inner_next
         assign next_d = cell_q[i+1];
      end
      bdq_cell #(
         .VALUE_BITS(VALUE_BITS)
      ) u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl),
         .from_prev(prev_d),
         .from_next(next_d),
         .q        (cell_q[i])
      );
   end

   assign store_val  = VALUE_BITS'(req_value);
   assign head_data  = DATA_BITS'(signed'(cell_q[0]));
   assign is_full    = (count_ff == CAP_CNT);
   assign no_entries = (count_ff == '0);
   assign pos_beyond = (CMP_W'(req_position) >= CMP_W'(count_ff));
   assign step_last  = (step_ff == LAST_IDX);
   assign step_cnt   = CNT_W'(step_ff);
   assign step_hit   = (step_cnt == tgt_ff);

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      op_in         = op_ff;
      tgt_in        = tgt_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_fpos_in   = res_fpos_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_fpos_in   = rsp_fpos_ff;
      rsp_count_in  = rsp_count_ff;
      cell_ctrl     = '0;
      head_in       = store_val;
      tail_in       = cell_q[0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in         = mode_type'(req_mode);
               val_in        = store_val;
               step_in       = '0;
               tgt_in        = '0;
               res_data_in   = '0;
               res_status_in = STATUS_OK;
               res_found_in  = 1'b0;
               res_fpos_in   = '0;
               state_in      = ST_DONE;
               case (mode_type'(req_mode))
                  MODE_APPEND: begin
                     if (is_full) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        tgt_in   = count_ff;
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_PREPEND: begin
                     if (is_full) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        cell_ctrl.shift_right = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  MODE_POP_FRONT, MODE_PEEK_FRONT: begin
                     if (no_entries) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        res_data_in = head_data;
                        if (mode_type'(req_mode) == MODE_POP_FRONT) begin
                           cell_ctrl.shift_left = 1'b1;
                           count_in = count_ff - 1'b1;
                        end
                     end
                  end
                  MODE_POP_BACK, MODE_PEEK_BACK: begin
                     if (no_entries) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        tgt_in   = count_ff - 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_READ, MODE_WRITE: begin
                     if (no_entries) begin
                        res_status_in = STATUS_EMPTY;
                     end else if (pos_beyond) begin
                        res_status_in = STATUS_RANGE;
                     end else begin
                        tgt_in   = CNT_W'(req_position);
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_SEARCH: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // rotate by one: the back cell takes the front one or the value written
            cell_ctrl.shift_left = 1'b1;
            step_in = step_last ? '0 : step_ff + 1'b1;
            case (op_ff)
               MODE_APPEND: begin
                  if (step_hit) begin
                     tail_in = val_ff;
                  end
                  if (step_last) begin
                     count_in = count_ff + 1'b1;
                  end
               end
               MODE_WRITE: begin
                  if (step_hit) begin
                     tail_in = val_ff;
                  end
               end
               MODE_POP_BACK: begin
                  if (step_hit) begin
                     res_data_in = head_data;
                  end
                  if (step_last) begin
                     count_in = count_ff - 1'b1;
                  end
               end
               MODE_PEEK_BACK, MODE_READ: begin
                  if (step_hit) begin
                     res_data_in = head_data;
                  end
               end
               MODE_SEARCH: begin
                  if (!res_found_ff && (step_cnt < count_ff) && (cell_q[0] == val_ff)) begin
                     res_found_in = 1'b1;
                     res_fpos_in  = POS_BITS'(step_ff);
                  end
               end
               default: begin
               end
            endcase
            if (step_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_fpos_in   = res_fpos_ff;
               rsp_count_in  = COUNT_BITS'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      op_ff         <= op_in;
      tgt_ff        <= tgt_in;
      val_ff        <= val_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_fpos_ff   <= res_fpos_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_fpos_ff   <= rsp_fpos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_data_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_count          = rsp_count_ff;

   `BDQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CAP_CNT, "entry count above capacity")
   `BDQ_ASSERT_NEXT(a_scan_ends, (state_ff == ST_SCAN) && step_last, (state_ff == ST_DONE) && (step_ff == '0), "rotation did not end after one full turn")
   `BDQ_ASSERT_NOW(a_full_count, (state_ff == ST_DONE) && (res_status_ff == STATUS_FULL), count_ff == CAP_CNT, "full status with room left")
   `BDQ_ASSERT_NEXT(a_result_moves, (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (state_ff == ST_IDLE), "finished result not moved to output")
   `BDQ_ASSERT_NOW(a_found_ok, rsp_valid_ff && rsp_found_ff, (rsp_status_ff == STATUS_OK) && (rsp_data_ff == '0), "search hit with bad status or data")

endmodule

### design/bdq_cell.sv
`timescale 1ns / 1ps

module bdq_cell import bdq_pkg::*; #(
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [VALUE_BITS-1:0] from_prev,
   input  logic [VALUE_BITS-1:0] from_next,
   output logic [VALUE_BITS-1:0] q
);

   logic [VALUE_BITS-1:0] q_ff;
   logic [VALUE_BITS-1:0] q_in;

   always_comb begin
      q_in = q_ff;
      if (ctrl.shift_left) begin
         q_in = from_next;
      end else if (ctrl.shift_right) begin
         q_in = from_prev;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import bdq_pkg::*;

   localparam int DEPTH = DEF_CAPACITY;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = DEF_CAPACITY + 6;
   localparam int RANDOM_PER_PHASE = 170;
   localparam logic [MODE_BITS-1:0] MODE_UNUSED_LO = 4'd9;
   localparam logic [MODE_BITS-1:0] MODE_UNUSED_HI = 4'd15;

   typedef struct packed {
      logic [DATA_BITS-1:0]  data;
      status_type            status;
      logic                  found;
      logic [POS_BITS-1:0]   found_position;
      logic [COUNT_BITS-1:0] count;
   } deque_result_type;

   typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_kind_type;

   class deque_scoreboard;
      logic [DATA_BITS-1:0] slots [DEPTH];
      int unsigned head;
      int unsigned held;
      deque_result_type pending [$];
      int errors;
      int requests;
      int checked;
      int full_hits;
      int empty_hits;
      int range_hits;
      int search_hits;

      task report(string field, logic [DATA_BITS-1:0] got, logic [DATA_BITS-1:0] want);
         $display("mismatch on %s at result %0d: got %0h want %0h", field, checked, got, want);
         errors++;
      endtask

      function void note_request(logic [MODE_BITS-1:0] mode, logic [DATA_BITS-1:0] value,
                                 logic [POS_BITS-1:0] pos);
         deque_result_type r;
         int unsigned i;
         r = '0;
         r.status = STATUS_OK;
         case (mode)
            MODE_APPEND, MODE_PREPEND: begin
               if (held == DEPTH) begin
                  r.status = STATUS_FULL;
               end else if (mode == MODE_APPEND) begin
                  slots[(head + held) % DEPTH] = value;
                  held++;
               end else begin
                  head = (head + DEPTH - 1) % DEPTH;
                  slots[head] = value;
                  held++;
               end
            end
            MODE_POP_FRONT, MODE_PEEK_FRONT: begin
               if (held == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  r.data = slots[head];
                  if (mode == MODE_POP_FRONT) begin
                     head = (head + 1) % DEPTH;
                     held--;
                  end
               end
            end
            MODE_POP_BACK, MODE_PEEK_BACK: begin
               if (held == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  r.data = slots[(head + held - 1) % DEPTH];
                  if (mode == MODE_POP_BACK)
                     held--;
               end
            end
            MODE_READ, MODE_WRITE: begin
               if (held == 0)
                  r.status = STATUS_EMPTY;
               else if (pos >= held)
                  r.status = STATUS_RANGE;
               else if (mode == MODE_READ)
                  r.data = slots[(head + pos) % DEPTH];
               else
                  slots[(head + pos) % DEPTH] = value;
            end
            MODE_SEARCH: begin
               for (i = 0; i < held; i++) begin
                  if (!r.found && slots[(head + i) % DEPTH] == value) begin
                     r.found = 1'b1;
                     r.found_position = POS_BITS'(i);
                  end
               end
               if (r.found)
                  search_hits++;
            end
            default: ;
         endcase
         case (r.status)
            STATUS_FULL:  full_hits++;
            STATUS_EMPTY: empty_hits++;
            STATUS_RANGE: range_hits++;
            default: ;
         endcase
         r.count = COUNT_BITS'(held);
         pending.push_back(r);
         requests++;
      endfunction

      task check_result(deque_result_type got);
         deque_result_type want;
         if (pending.size() == 0) begin
            report("unexpected result", got.data, '0);
         end else begin
            want = pending.pop_front();
            if (got.data !== want.data)
               report("data", got.data, want.data);
            if (got.status !== want.status)
               report("status", DATA_BITS'(got.status), DATA_BITS'(want.status));
            if (got.found !== want.found)
               report("found", DATA_BITS'(got.found), DATA_BITS'(want.found));
            if (got.found_position !== want.found_position)
               report("found_position", DATA_BITS'(got.found_position),
                      DATA_BITS'(want.found_position));
            if (got.count !== want.count)
               report("count", DATA_BITS'(got.count), DATA_BITS'(want.count));
         end
         checked++;
      endtask
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [MODE_BITS-1:0]         req_mode = '0;
   logic signed [DATA_BITS-1:0]  req_value = '0;
   logic [POS_BITS-1:0]          req_position = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [DATA_BITS-1:0]  rsp_data;
   logic [STATUS_BITS-1:0]       rsp_status;
   logic                         rsp_found;
   logic [POS_BITS-1:0]          rsp_found_position;
   logic [COUNT_BITS-1:0]        rsp_count;

   int send_idle = 6;
   int recv_idle = 80;
   int stall_cycles = 0;
   deque_scoreboard sb = new();
   logic [DATA_BITS-1:0] value_pool [4] = '{32'h0000_0011, 32'hdead_beef, 32'h8000_0001, 32'h0f0f_0f0f};

   bounded_deque_with_index_access_core #(
      .CAPACITY(DEPTH),
      .VALUE_BITS(DEF_VALUE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .rsp_status(rsp_status),
      .rsp_found(rsp_found),
      .rsp_found_position(rsp_found_position),
      .rsp_count(rsp_count)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin : monitor
      deque_result_type seen;
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_mode, req_value, req_position);
         if (rsp_valid && rsp_ready) begin
            seen.data = rsp_data;
            seen.status = status_type'(rsp_status);
            seen.found = rsp_found;
            seen.found_position = rsp_found_position;
            seen.count = rsp_count;
            sb.check_result(seen);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("no transfer for %0d cycles", STALL_LIMIT);
         $display("[bounded_deque_with_index_access_core] ERROR");
         $finish;
      end
   end

   task automatic send_request(logic [MODE_BITS-1:0] mode, logic [DATA_BITS-1:0] value,
                               logic [POS_BITS-1:0] pos);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_value <= value;
      req_position <= pos;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [DATA_BITS-1:0] pick_value();
      case ($urandom_range(3))
         0: return value_pool[$urandom_range(3)];
         1: begin
            case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [MODE_BITS-1:0] any_mode();
      if ($urandom_range(99) < 6)
         return MODE_BITS'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
      return MODE_BITS'($urandom_range(MODE_SEARCH));
   endfunction

   function automatic logic [MODE_BITS-1:0] pick_mode(burst_kind_type kind);
      int roll;
      roll = $urandom_range(99);
      case (kind)
         BURST_FILL: begin
            if (roll < 80)
               return $urandom_range(1) ? MODE_APPEND : MODE_PREPEND;
         end
         BURST_DRAIN: begin
            if (roll < 65)
               return $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
            if (roll < 80)
               return $urandom_range(1) ? MODE_PEEK_FRONT : MODE_PEEK_BACK;
         end
         default: ;
      endcase
      return any_mode();
   endfunction

   initial begin
      int phase;
      int issued;
      int len;
      int n;
      burst_kind_type kind;
      logic [MODE_BITS-1:0] mode;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // every removal and lookup on an empty deque
      send_request(MODE_POP_FRONT, 32'h0, 4'd0);
      send_request(MODE_POP_BACK, 32'h0, 4'd0);
      send_request(MODE_PEEK_FRONT, 32'h0, 4'd0);
      send_request(MODE_PEEK_BACK, 32'h0, 4'd0);
      send_request(MODE_READ, 32'h0, 4'd0);
      send_request(MODE_WRITE, 32'h1234_5678, 4'd15);
      send_request(MODE_SEARCH, 32'h0, 4'd0);
      // value extremes, duplicates, and the ring wrapping backwards
      send_request(MODE_APPEND, 32'h7fff_ffff, 4'd0);
      send_request(MODE_PREPEND, 32'h8000_0000, 4'd15);
      send_request(MODE_APPEND, 32'h0000_0000, 4'd0);
      send_request(MODE_APPEND, 32'hffff_ffff, 4'd0);
      send_request(MODE_APPEND, 32'h7fff_ffff, 4'd0);
      send_request(MODE_READ, 32'h0, 4'd0);
      send_request(MODE_READ, 32'h0, 4'd4);
      send_request(MODE_READ, 32'h0, 4'd5);
      send_request(MODE_WRITE, 32'h0, 4'd15);
      send_request(MODE_WRITE, 32'h5a5a_5a5a, 4'd2);
      send_request(MODE_SEARCH, 32'h7fff_ffff, 4'd0);
      send_request(MODE_SEARCH, 32'h5a5a_5a5a, 4'd0);
      send_request(MODE_SEARCH, 32'h1234_5678, 4'd0);
      send_request(MODE_PEEK_FRONT, 32'h0, 4'd0);
      send_request(MODE_PEEK_BACK, 32'h0, 4'd0);
      send_request(MODE_POP_FRONT, 32'h0, 4'd0);
      send_request(MODE_POP_BACK, 32'h0, 4'd0);
      send_request(MODE_UNUSED_LO, 32'hffff_ffff, 4'd15);
      send_request(MODE_UNUSED_HI, 32'h0, 4'd0);

      // fill bursts can run past full, drain bursts past empty
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle = 6;
               recv_idle = 80;
            end
            1: begin
               send_idle = 80;
               recv_idle = 6;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         issued = 0;
         while (issued < RANDOM_PER_PHASE) begin
            kind = burst_kind_type'($urandom_range(BURST_MIXED));
            len = $urandom_range(24, 4);
            for (n = 0; n < len; n++) begin
               mode = pick_mode(kind);
               if (mode == MODE_SEARCH && $urandom_range(1))
                  send_request(mode, value_pool[$urandom_range(3)], POS_BITS'($urandom));
               else
                  send_request(mode, pick_value(), POS_BITS'($urandom));
               if (mode <= MODE_SEARCH)
                  issued++;
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d requests, %0d results checked over three handshake pacing phases",
               sb.requests, sb.checked);
      $display("full %0d, empty %0d, out of range %0d, search hits %0d, mismatches %0d",
               sb.full_hits, sb.empty_hits, sb.range_hits, sb.search_hits, sb.errors);
      if (sb.errors == 0)
         $display("[bounded_deque_with_index_access_core] OK");
      else
         $display("[bounded_deque_with_index_access_core] ERROR");
      $finish;
   end

endmodule
